### design/pswd_pkg.sv
// ----------------------------------------------------------------------------
// pswd_pkg
// shared types for the port scan window detector
// ----------------------------------------------------------------------------
package pswd_pkg;

  localparam int ADDR_W = 32;
  localparam int PORT_W = 16;
  localparam int TIME_W = 32;
  localparam int CFG_W  = 16;

  // configuration register indexes
  localparam logic REG_TIME_WINDOW = 1'b0;
  localparam logic REG_PORT_LIMIT  = 1'b1;

  // one table entry plus its per-anchor scan flags
  typedef struct packed {
    logic [ADDR_W-1:0] src;
    logic [TIME_W-1:0] tstamp;
    logic [PORT_W-1:0] port;
    logic              valid;
    logic              inwin;
    logic              dup;
  } pswd_entry_t;

  // anchor broadcast to every cell
  typedef struct packed {
    logic [ADDR_W-1:0] src;
    logic [TIME_W-1:0] tstamp;
    logic              ok;
    logic [CFG_W-1:0]  window;
  } pswd_anchor_t;

  // per-cycle commands from the sequencer
  typedef struct packed {
    logic              shift;
    logic              cmp;
    logic              probe;
    logic              probe_hit;
    logic [PORT_W-1:0] probe_port;
  } pswd_ctrl_t;

endpackage

### design/port_scan_window_detector_top.sv
// ----------------------------------------------------------------------------
// port_scan_window_detector_top
// port scan detector over a bounded record table
// ----------------------------------------------------------------------------
// Each in_ transaction carries one connection record. The record is stored in
// the next free cell of a ring of TABLE_DEPTH cells (or dropped if the ring is
// full) and the block then returns one out_ transaction: is_intruder for that
// source and record_dropped.
// The ring rotates one cell per cycle in the probe and step states. For each
// anchor cell, the anchor state latches the anchor, the compare state marks
// in-window cells, the probe state rotates every entry past the head to count
// distinct ports, and the step state moves on to the next anchor. Records are
// taken one at a time.
// The finished result sits in an output register; the next record is accepted
// while it waits, but a second result holds in the sequencer until out_tready.
// Reset (rst_n low, synchronous) empties the table and restores window 5 and
// limit 3. Configuration writes take effect at once, also mid-record.
// ----------------------------------------------------------------------------
module port_scan_window_detector_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // source_address, dest_port, conn_time
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // is_intruder, record_dropped, zero fill
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  import pswd_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ANCH  = 3'd1;
  localparam logic [2:0] ST_CMP   = 3'd2;
  localparam logic [2:0] ST_PROBE = 3'd3;
  localparam logic [2:0] ST_STEP  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CW-1:0]     pc_r, pc_nxt, ac_r, ac_nxt;
  logic [CNT_W-1:0]  dist_r, dist_nxt;
  logic              hit_r, hit_nxt, drop_r, drop_nxt;
  logic [ADDR_W-1:0] q_src_r, q_src_nxt;
  logic [CFG_W-1:0]  win_r, lim_r;
  pswd_anchor_t      anc_r, anc_nxt;
  logic              ov_r, ov_nxt, oi_r, oi_nxt, od_r, od_nxt;

  pswd_entry_t       upd [TABLE_DEPTH];
  pswd_entry_t       wr_entry;
  pswd_ctrl_t        ctrl;
  logic              in_acc, wr_go, head_new;
  logic [CFG_W:0]    need, dist_ext;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign wr_go      = in_acc && (count_r < CNT_W'(TABLE_DEPTH));
  assign out_tvalid = ov_r;
  assign out_tdata  = {6'b0, od_r, oi_r};

  assign wr_entry.src    = in_tdata[31:0];
  assign wr_entry.port   = in_tdata[47:32];
  assign wr_entry.tstamp = in_tdata[79:48];
  assign wr_entry.valid  = 1'b1;
  assign wr_entry.inwin  = 1'b0;
  assign wr_entry.dup    = 1'b0;

  // sequencer commands to the ring
  assign ctrl.shift      = (state_r == ST_PROBE) || (state_r == ST_STEP);
  assign ctrl.cmp        = (state_r == ST_CMP);
  assign ctrl.probe      = (state_r == ST_PROBE);
  assign ctrl.probe_hit  = upd[0].inwin;
  assign ctrl.probe_port = upd[0].port;

  assign head_new = upd[0].inwin && !upd[0].dup;
  assign need     = (lim_r == '0) ? (CFG_W+1)'(1) : {1'b0, lim_r};
  assign dist_ext = (CFG_W+1)'(dist_r) + (CFG_W+1)'(1);

  // cell ring, cell i takes from cell i+1
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    pswd_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .wr_en     (wr_go && (count_r == CNT_W'(i))),
      .wr_entry  (wr_entry),
      .anchor    (anc_r),
      .ctrl      (ctrl),
      .nbr_entry (upd[(i + 1) % TABLE_DEPTH]),
      .upd_entry (upd[i])
    );
  end

  // control sequence
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    pc_nxt    = pc_r;
    ac_nxt    = ac_r;
    dist_nxt  = dist_r;
    hit_nxt   = hit_r;
    drop_nxt  = drop_r;
    q_src_nxt = q_src_r;
    anc_nxt   = anc_r;
    ov_nxt    = ov_r && !out_tready;
    oi_nxt    = oi_r;
    od_nxt    = od_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          q_src_nxt = in_tdata[31:0];
          drop_nxt  = !wr_go;
          hit_nxt   = 1'b0;
          ac_nxt    = '0;
          if (wr_go) begin
            count_nxt = count_r + CNT_W'(1);
          end
          state_nxt = ST_ANCH;
        end
      end
      ST_ANCH: begin
        anc_nxt.src    = upd[0].src;
        anc_nxt.tstamp = upd[0].tstamp;
        anc_nxt.ok     = upd[0].valid && (upd[0].src == q_src_r);
        anc_nxt.window = win_r;
        dist_nxt       = '0;
        state_nxt      = ST_CMP;
      end
      ST_CMP: begin
        pc_nxt    = '0;
        state_nxt = ST_PROBE;
      end
      ST_PROBE: begin
        if (head_new) begin
          dist_nxt = dist_r + CNT_W'(1);
          if (dist_ext >= need) begin
            hit_nxt = 1'b1;
          end
        end
        pc_nxt = pc_r + CW'(1);
        if (pc_r == CW'(TABLE_DEPTH - 1)) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        ac_nxt = ac_r + CW'(1);
        if (ac_r == CW'(TABLE_DEPTH - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_ANCH;
        end
      end
      ST_DONE: begin
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          oi_nxt    = hit_r;
          od_nxt    = drop_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
      win_r   <= CFG_W'(5);
      lim_r   <= CFG_W'(3);
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_TIME_WINDOW: win_r <= cfg_wdata;
          REG_PORT_LIMIT:  lim_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
    pc_r    <= pc_nxt;
    ac_r    <= ac_nxt;
    dist_r  <= dist_nxt;
    hit_r   <= hit_nxt;
    drop_r  <= drop_nxt;
    q_src_r <= q_src_nxt;
    anc_r   <= anc_nxt;
    oi_r    <= oi_nxt;
    od_r    <= od_nxt;
  end

endmodule

### design/pswd_cell.sv
// ----------------------------------------------------------------------------
// pswd_cell
// one table entry of the rotating record ring
// ----------------------------------------------------------------------------
module pswd_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  pswd_pkg::pswd_entry_t wr_entry,
  input  pswd_pkg::pswd_anchor_t anchor,
  input  pswd_pkg::pswd_ctrl_t  ctrl,
  input  pswd_pkg::pswd_entry_t nbr_entry,
  output pswd_pkg::pswd_entry_t upd_entry
);
  import pswd_pkg::*;

  pswd_entry_t       ent_r, ent_nxt, cmp_entry, shf_entry;
  logic [TIME_W-1:0] delta;

  assign delta     = ent_r.tstamp - anchor.tstamp;
  assign upd_entry = ent_r;

  // in-window flag for the current anchor
  always_comb begin
    cmp_entry       = ent_r;
    cmp_entry.inwin = ent_r.valid && anchor.ok && (ent_r.src == anchor.src) &&
                      (ent_r.tstamp >= anchor.tstamp) &&
                      (delta < {{(TIME_W-CFG_W){1'b0}}, anchor.window});
    cmp_entry.dup   = 1'b0;
  end

  // incoming entry, marked when the head already counted its port
  always_comb begin
    shf_entry = nbr_entry;
    if (ctrl.probe && ctrl.probe_hit && nbr_entry.inwin &&
        (nbr_entry.port == ctrl.probe_port)) begin
      shf_entry.dup = 1'b1;
    end
  end

  // load, rotate, compare or keep
  always_comb begin
    if (wr_en) begin
      ent_nxt = wr_entry;
    end else if (ctrl.shift) begin
      ent_nxt = shf_entry;
    end else if (ctrl.cmp) begin
      ent_nxt = cmp_entry;
    end else begin
      ent_nxt = ent_r;
    end
    if (!rst_n) begin
      ent_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule
